### src/hrhw_pkg.sv
package hrhw_pkg;

   localparam int unsigned POS_WIDTH    = 10;
   localparam int unsigned QUEUE_DEPTH  = 4;
   localparam int unsigned QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

   localparam logic [POS_WIDTH-1:0] POS_MAX      = 10'd1023;
   localparam logic [POS_WIDTH-1:0] POS_COUNT_LO = 10'd1;
   localparam logic [POS_WIDTH-1:0] POS_COUNT_HI = 10'd2;
   localparam logic [POS_WIDTH-1:0] POS_ADDR_HI  = 10'd6;
   localparam logic [POS_WIDTH-1:0] POS_TYPE     = 10'd8;
   localparam logic [POS_WIDTH-1:0] POS_DATA     = 10'd9;

   localparam logic [7:0]  CHAR_ZERO  = 8'd48;
   localparam logic [7:0]  CHAR_NINE  = 8'd57;
   localparam logic [7:0]  CHAR_ONE   = 8'd49;
   localparam logic [7:0]  ALPHA_BIAS = 8'd55;
   localparam logic [15:0] UPPER_ADDRESS_RESET = 16'h0800;

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_EOF   = 1'b1;

   typedef struct packed {
      logic        kind;
      logic [15:0] record_address;
      logic [6:0]  halfword_index;
      logic [15:0] data;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [3:0] hex_digit(input logic [7:0] c);
      logic [7:0] biased;
      biased = c - ALPHA_BIAS;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         return c[3:0];
      end
      return biased[3:0];
   endfunction

endpackage

### src/hex_record_to_halfword_writes_core.sv
// Channel   Direction  Handshake            Payload
// req_      in         push / full          character, record_start
// rsp_      out        pop / empty          result_kind, write_address, write_data
// csr_      in         wr_en (no wait)      upper_address
//
// One character is taken every cycle while req_full is low; the parser updates
// its record state in the accepting cycle. A result goes to rsp_ through the
// command queue, written at the accepting edge, and then the output register
// that adds the record address to the upper address, loaded when empty or popped.
// The command queue holds four results; req_full rises when it is full.
// Synchronous reset clears all control state and loads upper_address with 0x0800.
module hex_record_to_halfword_writes_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_character,
   input  logic        req_record_start,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_result_kind,
   output logic [31:0] rsp_write_address,
   output logic [15:0] rsp_write_data,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   hrhw_pkg::cmd_type          front_cmd, head_cmd;
   hrhw_pkg::queue_status_type qstatus;
   logic                       accept, cmd_push, head_pop;

   assign req_full = qstatus.full;
   assign accept   = req_push && !qstatus.full;

   hrhw_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .character    (req_character),
      .record_start (req_record_start),
      .cmd_push     (cmd_push),
      .cmd          (front_cmd)
   );

   hrhw_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (front_cmd),
      .pop      (head_pop),
      .head_cmd (head_cmd),
      .status   (qstatus)
   );

   hrhw_back u_back (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .head_cmd          (head_cmd),
      .qstatus           (qstatus),
      .head_pop          (head_pop),
      .rsp_pop           (rsp_pop),
      .rsp_empty         (rsp_empty),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_write_address (rsp_write_address),
      .rsp_write_data    (rsp_write_data)
   );

endmodule

### src/hrhw_front.sv
module hrhw_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          character,
   input  logic                record_start,
   output logic                cmd_push,
   output hrhw_pkg::cmd_type   cmd
);

   logic [hrhw_pkg::POS_WIDTH-1:0] pos_ff, pos_in, p, p_off;
   logic [7:0]  count_ff, count_in;
   logic [15:0] addr_ff, addr_in;
   logic        is_data_ff, is_data_in;
   logic [11:0] nib_ff, nib_in;
   logic [6:0]  index_ff, index_in;
   logic [3:0]  d;
   logic        emit;

   always_comb begin
      p          = record_start ? '0 : pos_ff;
      p_off      = p - hrhw_pkg::POS_DATA;
      d          = hrhw_pkg::hex_digit(character);
      count_in   = count_ff;
      addr_in    = addr_ff;
      is_data_in = is_data_ff;
      nib_in     = nib_ff;
      index_in   = index_ff;
      emit       = 1'b0;
      cmd.kind           = hrhw_pkg::KIND_WRITE;
      cmd.record_address = addr_ff;
      cmd.halfword_index = index_ff;
      cmd.data           = {nib_ff[3:0], d, nib_ff[11:8], nib_ff[7:4]};
      priority if (p == '0) begin
         count_in   = '0;
         addr_in    = '0;
         is_data_in = 1'b0;
         nib_in     = '0;
         index_in   = '0;
      end else if (p <= hrhw_pkg::POS_COUNT_HI) begin
         count_in = {count_ff[3:0], d};
      end else if (p <= hrhw_pkg::POS_ADDR_HI) begin
         addr_in = {addr_ff[11:0], d};
      end else if (p == hrhw_pkg::POS_TYPE) begin
         is_data_in = (character == hrhw_pkg::CHAR_ZERO);
         if (character == hrhw_pkg::CHAR_ONE) begin
            emit = 1'b1;
            cmd.kind           = hrhw_pkg::KIND_EOF;
            cmd.record_address = '0;
            cmd.halfword_index = '0;
            cmd.data           = '0;
         end
      end else if (p >= hrhw_pkg::POS_DATA) begin
         if (p_off[1:0] == 2'b11) begin
            if (is_data_ff && index_ff < count_ff[7:1]) begin
               emit     = 1'b1;
               index_in = index_ff + 7'd1;
            end
            nib_in = '0;
         end else begin
            nib_in = {nib_ff[7:0], d};
         end
      end else begin
         nib_in = nib_ff;
      end
      pos_in = (p < hrhw_pkg::POS_MAX) ? p + hrhw_pkg::POS_COUNT_LO : hrhw_pkg::POS_MAX;
   end

   assign cmd_push = accept && emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         count_ff   <= '0;
         addr_ff    <= '0;
         is_data_ff <= 1'b0;
         nib_ff     <= '0;
         index_ff   <= '0;
      end else if (accept) begin
         pos_ff     <= pos_in;
         count_ff   <= count_in;
         addr_ff    <= addr_in;
         is_data_ff <= is_data_in;
         nib_ff     <= nib_in;
         index_ff   <= index_in;
      end
   end

endmodule

### src/hrhw_queue.sv
module hrhw_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  hrhw_pkg::cmd_type           push_cmd,
   input  logic                        pop,
   output hrhw_pkg::cmd_type           head_cmd,
   output hrhw_pkg::queue_status_type  status
);

   hrhw_pkg::cmd_type slots_ff [hrhw_pkg::QUEUE_DEPTH];
   logic [hrhw_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [hrhw_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign status.full  = (count_ff == hrhw_pkg::QUEUE_CNT_W'(hrhw_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push  = push && !status.full;
   assign do_pop   = pop && !status.empty;
   assign head_cmd = slots_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

endmodule

### src/hrhw_back.sv
module hrhw_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [15:0]                 csr_wr_data,
   input  hrhw_pkg::cmd_type           head_cmd,
   input  hrhw_pkg::queue_status_type  qstatus,
   output logic                        head_pop,
   input  logic                        rsp_pop,
   output logic                        rsp_empty,
   output logic                        rsp_result_kind,
   output logic [31:0]                 rsp_write_address,
   output logic [15:0]                 rsp_write_data
);

   logic [15:0] upper_ff;
   logic        valid_ff;
   logic        kind_ff;
   logic [31:0] address_ff, address_in;
   logic [15:0] data_ff;
   logic        load;

   assign load     = !qstatus.empty && (!valid_ff || rsp_pop);
   assign head_pop = load;

   always_comb begin
      if (head_cmd.kind == hrhw_pkg::KIND_EOF) begin
         address_in = '0;
      end else begin
         address_in = {upper_ff, head_cmd.record_address}
                    + {24'd0, head_cmd.halfword_index, 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff <= hrhw_pkg::UPPER_ADDRESS_RESET;
      end else if (csr_wr_en) begin
         upper_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_pop) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff    <= head_cmd.kind;
         address_ff <= address_in;
         data_ff    <= head_cmd.data;
      end
   end

   assign rsp_empty         = !valid_ff;
   assign rsp_result_kind   = kind_ff;
   assign rsp_write_address = address_ff;
   assign rsp_write_data    = data_ff;

endmodule

### src/hrhw_checker.sv
module hrhw_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_full,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic        rsp_result_kind,
   input logic [31:0] rsp_write_address,
   input logic [15:0] rsp_write_data
);

   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty && !req_full)
      else $error("queue not empty after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_result_kind)
         && $stable(rsp_write_address) && $stable(rsp_write_data))
      else $error("waiting result changed before pop");

   a_eof_zero: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_result_kind == hrhw_pkg::KIND_EOF |-> rsp_write_address == 32'd0
         && rsp_write_data == 16'd0)
      else $error("end of file result carries nonzero payload");

   a_full_needs_backlog: assert property (@(posedge clock) disable iff (reset)
      req_full |-> !rsp_empty)
      else $error("request side full while no result waits");

endmodule

bind hex_record_to_halfword_writes_core hrhw_checker u_hrhw_checker (
   .clock             (clock),
   .reset             (reset),
   .req_full          (req_full),
   .rsp_empty         (rsp_empty),
   .rsp_pop           (rsp_pop),
   .rsp_result_kind   (rsp_result_kind),
   .rsp_write_address (rsp_write_address),
   .rsp_write_data    (rsp_write_data)
);

### verif/tb.sv
`timescale 1ns / 100ps

module tb;

   localparam int unsigned IDLE_LIMIT = 3000;
   localparam logic [7:0]  COLON      = 8'h3A;
   localparam logic [7:0]  UPPER_A    = 8'h41;
   localparam logic [7:0]  LOWER_A    = 8'h61;
   localparam logic [7:0]  CHAR_CR    = 8'h0D;
   localparam logic [7:0]  CHAR_LF    = 8'h0A;

   typedef struct packed {
      logic        kind;
      logic [31:0] address;
      logic [15:0] data;
   } flash_write_type;

   class halfword_scoreboard;
      bit [15:0]       upper;
      bit [9:0]        position;
      bit [7:0]        count;
      bit [15:0]       rec_addr;
      bit              data_rec;
      bit [11:0]       nibbles;
      bit [6:0]        hw_index;
      flash_write_type expected_writes[$];
      int              mismatches;

      function new();
         upper = hrhw_pkg::UPPER_ADDRESS_RESET;
         position = '0;
         count = '0;
         rec_addr = '0;
         data_rec = 1'b0;
         nibbles = '0;
         hw_index = '0;
         mismatches = 0;
      endfunction

      function void set_upper(bit [15:0] value);
         upper = value;
      endfunction

      function void note_char(bit [7:0] c, bit start);
         bit [9:0]        p;
         bit [9:0]        rel;
         bit [7:0]        off;
         bit [3:0]        d;
         flash_write_type w;
         p = start ? 10'd0 : position;
         off = (c >= hrhw_pkg::CHAR_ZERO && c <= hrhw_pkg::CHAR_NINE)
             ? c - hrhw_pkg::CHAR_ZERO : c - hrhw_pkg::ALPHA_BIAS;
         d = off[3:0];
         if (p == 10'd0) begin
            count = '0;
            rec_addr = '0;
            data_rec = 1'b0;
            nibbles = '0;
            hw_index = '0;
         end else if (p <= hrhw_pkg::POS_COUNT_HI) begin
            count = {count[3:0], d};
         end else if (p <= hrhw_pkg::POS_ADDR_HI) begin
            rec_addr = {rec_addr[11:0], d};
         end else if (p == hrhw_pkg::POS_TYPE) begin
            data_rec = (c == hrhw_pkg::CHAR_ZERO);
            if (c == hrhw_pkg::CHAR_ONE) begin
               w.kind = hrhw_pkg::KIND_EOF;
               w.address = '0;
               w.data = '0;
               expected_writes.push_back(w);
            end
         end else if (p >= hrhw_pkg::POS_DATA) begin
            rel = p - hrhw_pkg::POS_DATA;
            if (rel[1:0] == 2'd3) begin
               if (data_rec && hw_index < count[7:1]) begin
                  w.kind = hrhw_pkg::KIND_WRITE;
                  w.address = {upper, rec_addr} + {24'd0, hw_index, 1'b0};
                  w.data = {nibbles[3:0], d, nibbles[11:8], nibbles[7:4]};
                  expected_writes.push_back(w);
                  hw_index = hw_index + 7'd1;
               end
               nibbles = '0;
            end else begin
               nibbles = {nibbles[7:0], d};
            end
         end
         position = (p < hrhw_pkg::POS_MAX) ? p + 10'd1 : hrhw_pkg::POS_MAX;
      endfunction

      function void check_result(logic kind, logic [31:0] address, logic [15:0] data);
         flash_write_type w;
         if (expected_writes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected result kind=%0d address=%h data=%h", kind, address, data);
            end
            return;
         end
         w = expected_writes.pop_front();
         if (kind !== w.kind || address !== w.address || data !== w.data) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display({"mismatch: expected kind=%0d address=%h data=%h,",
                         " got kind=%0d address=%h data=%h"},
                        w.kind, w.address, w.data, kind, address, data);
            end
         end
      endfunction

      function int outstanding();
         return expected_writes.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   logic [7:0]  req_character;
   logic        req_record_start;
   logic        rsp_empty;
   logic        rsp_pop;
   logic        rsp_result_kind;
   logic [31:0] rsp_write_address;
   logic [15:0] rsp_write_data;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;

   halfword_scoreboard sb;
   bit                 calm;
   int                 char_total;
   int                 idle_cycles;

   hex_record_to_halfword_writes_core DUT (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_character(req_character),
      .req_record_start(req_record_start),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_result_kind(rsp_result_kind),
      .rsp_write_address(rsp_write_address),
      .rsp_write_data(rsp_write_data),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 1'b0;
   end

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) begin
         return 0;
      end
      if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   function automatic bit [7:0] hex_char(bit [3:0] v, bit lower);
      if (v < 4'd10) begin
         return hrhw_pkg::CHAR_ZERO + {4'd0, v};
      end
      return (lower ? LOWER_A : UPPER_A) + {4'd0, v} - 8'd10;
   endfunction

   function automatic bit [7:0] data_char();
      int r;
      r = $urandom_range(0, 99);
      if (r < 90) begin
         return hex_char(4'($urandom_range(0, 15)), 1'b0);
      end
      if (r < 95) begin
         return hex_char(4'($urandom_range(0, 15)), 1'b1);
      end
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic push_char(input bit [7:0] c, input bit start);
      int gap;
      gap = calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_push = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_character = c;
      req_record_start = start;
      req_push = 1'b1;
      do begin
         @(posedge clock);
      end while (req_full);
      sb.note_char(c, start);
      char_total++;
      @(negedge clock);
   endtask

   task automatic write_upper(input bit [15:0] value);
      req_push = 1'b0;
      while (sb.outstanding() != 0) begin
         @(negedge clock);
      end
      repeat (4) @(negedge clock);
      csr_wr_data = value;
      csr_wr_en = 1'b1;
      @(negedge clock);
      csr_wr_en = 1'b0;
      sb.set_upper(value);
   endtask

   task automatic send_record(input bit [7:0] first, input bit marked, input bit [7:0] count,
                              input bit [15:0] address, input bit [7:0] rec_type,
                              input int data_len, input bit trailer);
      push_char(first, marked);
      push_char(hex_char(count[7:4], 1'b0), 1'b0);
      push_char(hex_char(count[3:0], 1'b0), 1'b0);
      for (int i = 3; i >= 0; i--) begin
         push_char(hex_char(address[i*4 +: 4], 1'b0), 1'b0);
      end
      push_char(hrhw_pkg::CHAR_ZERO, 1'b0);
      push_char(rec_type, 1'b0);
      for (int i = 0; i < data_len; i++) begin
         push_char(data_char(), 1'b0);
      end
      push_char(data_char(), 1'b0);
      push_char(data_char(), 1'b0);
      if (trailer) begin
         push_char(CHAR_CR, 1'b0);
         push_char(CHAR_LF, 1'b0);
      end
   endtask

   task automatic random_record();
      int       r;
      int       k;
      int       len;
      bit [7:0] cnt;
      bit [7:0] rt;
      bit [7:0] first;
      r = $urandom_range(0, 99);
      if (r < 12) begin
         repeat ($urandom_range(1, 8)) begin
            push_char(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
         end
         return;
      end
      cnt = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 12))
                                        : 8'($urandom_range(13, 40));
      k = $urandom_range(0, 99);
      if (k < 65) begin
         rt = hrhw_pkg::CHAR_ZERO;
      end else if (k < 80) begin
         rt = hrhw_pkg::CHAR_ONE;
      end else if (k < 92) begin
         rt = 8'($urandom_range(50, 53));
      end else begin
         rt = 8'($urandom_range(0, 255));
      end
      len = cnt * 2;
      if ($urandom_range(0, 99) < 15) begin
         len = $urandom_range(0, cnt * 2 + 6);
      end
      first = (r < 88) ? COLON : 8'($urandom_range(0, 255));
      send_record(first, !(r >= 80 && r < 88), cnt, 16'($urandom_range(0, 65535)), rt, len,
                  1'($urandom_range(0, 1)));
   endtask

   initial begin
      bit [15:0] uppers[6];
      int        target;
      sb = new();
      reset = 1'b1;
      req_push = 1'b0;
      req_character = '0;
      req_record_start = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      calm = 1'b0;
      char_total = 0;
      uppers[0] = 16'h0000;
      uppers[1] = 16'($urandom_range(0, 65535));
      uppers[2] = 16'h0800;
      uppers[3] = 16'($urandom_range(0, 65535));
      uppers[4] = 16'hFFFF;
      uppers[5] = 16'($urandom_range(0, 65535));
      repeat (9) @(negedge clock);
      reset = 1'b0;

      write_upper(16'hFFFF);
      send_record(COLON, 1'b1, 8'h04, 16'hFFFE, hrhw_pkg::CHAR_ZERO, 8, 1'b0);
      send_record(COLON, 1'b1, 8'h00, 16'h0000, hrhw_pkg::CHAR_ONE, 0, 1'b0);

      for (int phase = 0; phase < 6; phase++) begin
         write_upper(uppers[phase]);
         calm = (phase == 2);
         target = char_total + 65;
         if (phase == 3) begin
            send_record(COLON, 1'b1, 8'hFF, 16'($urandom_range(0, 65535)),
                        hrhw_pkg::CHAR_ZERO, 60, 1'b1);
         end
         while (char_total < target) begin
            random_record();
         end
      end
      calm = 1'b0;

      req_push = 1'b0;
      while (sb.outstanding() != 0) begin
         @(negedge clock);
      end
      repeat (8) @(negedge clock);
      if (sb.mismatches == 0 && sb.outstanding() == 0) begin
         $display("hex_record_to_halfword_writes_core regression: pass");
      end else begin
         $display("hex_record_to_halfword_writes_core regression: fail");
      end
      $finish;
   end

   initial begin
      int stall_left;
      stall_left = 0;
      rsp_pop = 1'b0;
      forever begin
         @(negedge clock);
         if (calm) begin
            rsp_pop = 1'b1;
         end else if (stall_left > 0) begin
            rsp_pop = 1'b0;
            stall_left--;
         end else begin
            rsp_pop = 1'b1;
            stall_left = pick_gap();
         end
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) begin
            sb.check_result(rsp_result_kind, rsp_write_address, rsp_write_data);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("hex_record_to_halfword_writes_core regression: fail");
            $finish;
         end
      end
   end

endmodule

### filelist.f
src/hrhw_pkg.sv
src/hrhw_front.sv
src/hrhw_queue.sv
src/hrhw_back.sv
src/hex_record_to_halfword_writes_core.sv
src/hrhw_checker.sv
verif/tb.sv
